### src/brx_pkg.sv
// Shared types and constants for the bit reader with Exp-Golomb decoding.
// No dependencies.
package brx_pkg;

  localparam int BUF_BYTES = 2048;
  localparam int ADDR_W = $clog2(BUF_BYTES);
  localparam int IDX_W = $clog2(BUF_BYTES + 1);
  localparam int MAX_READ_BITS = 24;
  localparam int MAX_BYTE_BITS = 512;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_LOAD  = 3'd1,
    MODE_BITS  = 3'd2,
    MODE_EXPG  = 3'd3,
    MODE_BYTES = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    OP_START,
    OP_LOAD,
    OP_BITS,
    OP_EXPG,
    OP_BYTES,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SIZE = 2'd1,
    ST_END  = 2'd2
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] length;
    logic [7:0]  data_byte;
    logic [9:0]  bit_count;
  } request_t;

endpackage

### src/brx_front.sv
// Front end: takes requests, classifies the mode and queues them for the back end.
// Depends on brx_pkg.
module brx_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        mode,
  input  logic [11:0]       length,
  input  logic [7:0]        data_byte,
  input  logic [9:0]        bit_count,
  output logic              req_valid,
  output brx_pkg::request_t req,
  input  logic              req_take
);

  brx_pkg::request_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  brx_pkg::request_t incoming;
  logic push;
  logic pop;

  always_comb begin
    incoming.length = length;
    incoming.data_byte = data_byte;
    incoming.bit_count = bit_count;
    case (mode)
      brx_pkg::MODE_START: incoming.op = brx_pkg::OP_START;
      brx_pkg::MODE_LOAD:  incoming.op = brx_pkg::OP_LOAD;
      brx_pkg::MODE_BITS:  incoming.op = brx_pkg::OP_BITS;
      brx_pkg::MODE_EXPG:  incoming.op = brx_pkg::OP_EXPG;
      brx_pkg::MODE_BYTES: incoming.op = brx_pkg::OP_BYTES;
      default:             incoming.op = brx_pkg::OP_NONE;
    endcase
  end

  assign in_ready = (fill != 2'd2);
  assign push = in_valid && in_ready;
  assign req_valid = (fill != 2'd0);
  assign pop = req_valid && req_take;
  assign req = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### src/brx_back.sv
// Back end: byte store, bit window refill, Exp-Golomb and byte-run sequencing.
// Depends on brx_pkg.
module brx_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  brx_pkg::request_t req,
  output logic              req_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       value,
  output logic [1:0]        status,
  output logic              last
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_FETCH = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    JOB_BITS,
    JOB_PREFIX,
    JOB_SUFFIX,
    JOB_BYTES
  } job_t;

  logic [7:0] mem [brx_pkg::BUF_BYTES];
  logic [7:0] mem_rdata;

  state_t state;
  job_t   job;
  logic [brx_pkg::IDX_W-1:0] write_index;
  logic [brx_pkg::IDX_W-1:0] buffer_length;
  logic [brx_pkg::IDX_W-1:0] read_index;
  logic [31:0] bit_window;
  logic [5:0]  window_position;
  logic        end_reached;
  logic        buffer_set;

  logic [5:0] n;          // bits in the current read
  logic [5:0] zeros;
  logic [1:0] pre_status;
  logic [6:0] bytes_left;
  logic [2:0] rem;

  // single read step
  logic        rd_ok;
  logic        refill;
  logic        hit_end;
  logic [1:0]  rd_s;
  logic [31:0] rd_v;
  logic [31:0] aligned;
  logic [6:0]  room;

  logic [32:0] mask;
  logic [6:0]  left_after;
  logic        byte_full;
  logic [7:0]  part_byte;
  logic        mem_we;
  logic        mem_re;

  assign aligned = bit_window << window_position;
  assign room = 7'd32 - {1'b0, window_position};

  always_comb begin
    rd_ok = 1'b0;
    refill = 1'b0;
    hit_end = 1'b0;
    rd_s = brx_pkg::ST_OK;
    rd_v = '0;
    if (n == 6'd0) begin
      rd_s = brx_pkg::ST_OK;
    end else if (!buffer_set || n > 6'(brx_pkg::MAX_READ_BITS)) begin
      rd_s = brx_pkg::ST_SIZE;
    end else if (end_reached) begin
      rd_s = brx_pkg::ST_END;
    end else if (room < {1'b0, n}) begin
      if (read_index >= buffer_length) begin
        hit_end = 1'b1;
        rd_s = brx_pkg::ST_END;
      end else begin
        refill = 1'b1;
      end
    end else begin
      rd_ok = 1'b1;
      rd_v = aligned >> (6'd32 - n);
    end
  end

  assign mask = (33'd1 << zeros) - 33'd1;
  assign byte_full = (bytes_left != 7'd0);
  assign left_after = byte_full ? bytes_left - 7'd1 : bytes_left;
  assign part_byte = rd_v[7:0] << (4'd8 - {1'b0, rem});

  assign req_take = (state == S_IDLE);
  assign mem_we = (state == S_IDLE) && req_valid && (req.op == brx_pkg::OP_LOAD)
                  && (write_index < brx_pkg::IDX_W'(brx_pkg::BUF_BYTES));
  assign mem_re = (state == S_READ) && refill;

  always_ff @(posedge clk) begin
    if (mem_we) mem[write_index[brx_pkg::ADDR_W-1:0]] <= req.data_byte;
    if (mem_re) mem_rdata <= mem[read_index[brx_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job <= JOB_BITS;
      write_index <= '0;
      buffer_length <= '0;
      read_index <= '0;
      bit_window <= '0;
      window_position <= 6'd32;
      end_reached <= 1'b0;
      buffer_set <= 1'b0;
      out_valid <= 1'b0;
      n <= '0;
      zeros <= '0;
      pre_status <= '0;
      bytes_left <= '0;
      rem <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            case (req.op)
              brx_pkg::OP_START: begin
                buffer_length <= (req.length > 12'(brx_pkg::BUF_BYTES))
                                 ? brx_pkg::IDX_W'(brx_pkg::BUF_BYTES)
                                 : brx_pkg::IDX_W'(req.length);
                write_index <= '0;
                read_index <= '0;
                bit_window <= '0;
                window_position <= 6'd32;
                end_reached <= 1'b0;
                buffer_set <= 1'b1;
              end
              brx_pkg::OP_LOAD: begin
                if (mem_we) write_index <= write_index + 1'b1;
              end
              brx_pkg::OP_BITS: begin
                job <= JOB_BITS;
                n <= (req.bit_count > 10'd32) ? 6'd63 : req.bit_count[5:0];
                state <= S_READ;
              end
              brx_pkg::OP_EXPG: begin
                if (!buffer_set) begin
                  value <= '0;
                  status <= brx_pkg::ST_SIZE;
                  last <= 1'b1;
                  out_valid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  job <= JOB_PREFIX;
                  zeros <= '0;
                  n <= 6'd1;
                  state <= S_READ;
                end
              end
              brx_pkg::OP_BYTES: begin
                if (req.bit_count == 10'd0
                    || req.bit_count > 10'(brx_pkg::MAX_BYTE_BITS)) begin
                  value <= '0;
                  status <= (req.bit_count == 10'd0) ? brx_pkg::ST_OK : brx_pkg::ST_SIZE;
                  last <= 1'b1;
                  out_valid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  job <= JOB_BYTES;
                  bytes_left <= req.bit_count[9:3];
                  rem <= req.bit_count[2:0];
                  n <= (req.bit_count[9:3] != 7'd0) ? 6'd8 : {3'd0, req.bit_count[2:0]};
                  state <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          if (refill) begin
            state <= S_FETCH;
          end else begin
            if (hit_end) end_reached <= 1'b1;
            if (rd_ok) window_position <= window_position + n;
            case (job)
              JOB_BITS: begin
                value <= rd_v;
                status <= rd_s;
                last <= 1'b1;
                out_valid <= 1'b1;
                state <= S_OUT;
              end
              JOB_PREFIX: begin
                if (rd_s != brx_pkg::ST_OK || rd_v[0]) begin
                  pre_status <= rd_s;
                  n <= zeros;
                  job <= JOB_SUFFIX;
                end else if (zeros != 6'd32) begin
                  zeros <= zeros + 6'd1;
                end
              end
              JOB_SUFFIX: begin
                value <= mask[31:0] + rd_v;
                status <= (pre_status != brx_pkg::ST_OK) ? pre_status : rd_s;
                last <= 1'b1;
                out_valid <= 1'b1;
                state <= S_OUT;
              end
              JOB_BYTES: begin
                value <= {24'd0, byte_full ? rd_v[7:0] : part_byte};
                status <= rd_s;
                last <= byte_full ? (bytes_left == 7'd1 && rem == 3'd0) : 1'b1;
                out_valid <= 1'b1;
                bytes_left <= left_after;
                if (!byte_full) rem <= 3'd0;
                n <= (left_after != 7'd0) ? 6'd8 : {3'd0, rem};
                state <= S_OUT;
              end
              default: begin
              end
            endcase
          end
        end
        S_FETCH: begin
          bit_window <= {bit_window[23:0], mem_rdata};
          window_position <= window_position - 6'd8;
          read_index <= read_index + 1'b1;
          state <= S_READ;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= (job == JOB_BYTES && !last) ? S_READ : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/bitstream_reader_exp_golomb.sv
// Sequence: a read request is taken in idle and then read; each byte refilled into the
// window passes through a fetch state and back to read; an Exp-Golomb request adds one
// read step per prefix bit; a byte run gives one result per read step. Start, load and
// unused modes are handled in idle. A read request holds the back end through take, read
// and result; each further byte of a run goes from result back to read. Requests pass a 2-entry queue.
// Reset: synchronous, clears positions, flags and queue; the byte store is not cleared.
module bitstream_reader_exp_golomb (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [11:0] length,
  input  logic [7:0]  data_byte,
  input  logic [9:0]  bit_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [1:0]  status,
  output logic        last
);

  brx_pkg::request_t req;
  logic req_valid;
  logic req_take;

  brx_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .length(length), .data_byte(data_byte), .bit_count(bit_count),
    .req_valid(req_valid), .req(req), .req_take(req_take)
  );

  brx_back u_back (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req(req), .req_take(req_take),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .status(status), .last(last)
  );

endmodule

### dv/tb_bitstream_reader_exp_golomb.sv
// Testbench for bitstream_reader_exp_golomb: random and directed requests, with results
// checked against a cycle-free predictor held in a scoreboard class.
// Depends on brx_pkg and the bitstream_reader_exp_golomb RTL.
module tb_bitstream_reader_exp_golomb;

  class reader_scoreboard;
    typedef struct {
      bit [31:0]         value;
      brx_pkg::status_t  status;
      bit                last;
    } read_result_t;

    read_result_t expected_reads[$];
    bit [7:0]  store [brx_pkg::BUF_BYTES];
    int        wr_idx, buf_len, rd_idx, win_pos;
    bit [31:0] window;
    bit        at_end, buf_set;
    int        errors, accepted;

    function new();
      win_pos = 32;
    endfunction

    function brx_pkg::status_t take_bits(int n, output bit [31:0] v);
      bit [31:0] aligned;
      v = 0;
      if (n == 0) return brx_pkg::ST_OK;
      if (!buf_set || n > brx_pkg::MAX_READ_BITS) return brx_pkg::ST_SIZE;
      if (at_end) return brx_pkg::ST_END;
      while (32 - win_pos < n) begin
        if (rd_idx >= buf_len) begin
          at_end = 1;
          return brx_pkg::ST_END;
        end
        win_pos -= 8;
        window = {window[23:0], store[rd_idx]};
        rd_idx++;
      end
      aligned = window << win_pos;
      v = aligned >> (32 - n);
      win_pos += n;
      return brx_pkg::ST_OK;
    endfunction

    function void push(bit [31:0] v, brx_pkg::status_t s, bit l);
      read_result_t r;
      r.value = v;
      r.status = s;
      r.last = l;
      expected_reads.push_back(r);
    endfunction

    function void note_request(bit [2:0] m, bit [11:0] len, bit [7:0] db, bit [9:0] cnt);
      bit [31:0] v, bitv, suffix;
      bit [32:0] sum;
      brx_pkg::status_t ps, ss, s;
      int        zeros, nbytes, rem;
      accepted++;
      case (m)
        brx_pkg::MODE_START: begin
          buf_len = (len > brx_pkg::BUF_BYTES) ? brx_pkg::BUF_BYTES : len;
          wr_idx = 0;
          rd_idx = 0;
          window = 0;
          win_pos = 32;
          at_end = 0;
          buf_set = 1;
        end
        brx_pkg::MODE_LOAD: begin
          if (wr_idx < brx_pkg::BUF_BYTES) begin
            store[wr_idx] = db;
            wr_idx++;
          end
        end
        brx_pkg::MODE_BITS: begin
          s = take_bits(cnt, v);
          push(v, s, 1);
        end
        brx_pkg::MODE_EXPG: begin
          if (!buf_set) begin
            push(0, brx_pkg::ST_SIZE, 1);
          end else begin
            zeros = 0;
            forever begin
              ps = take_bits(1, bitv);
              if (ps != brx_pkg::ST_OK || bitv != 0) break;
              if (zeros < 32) zeros++;
            end
            ss = take_bits(zeros, suffix);
            sum = (33'd1 << zeros) - 33'd1 + suffix;
            push(sum[31:0], (ps != brx_pkg::ST_OK) ? ps : ss, 1);
          end
        end
        brx_pkg::MODE_BYTES: begin
          nbytes = cnt >> 3;
          rem = cnt & 7;
          if (cnt == 0 || cnt > brx_pkg::MAX_BYTE_BITS) begin
            push(0, (cnt == 0) ? brx_pkg::ST_OK : brx_pkg::ST_SIZE, 1);
          end else begin
            for (int i = 0; i < nbytes; i++) begin
              s = take_bits(8, v);
              push(v & 32'hFF, s, (i + 1 == nbytes && rem == 0));
            end
            if (rem > 0) begin
              s = take_bits(rem, v);
              push((v << (8 - rem)) & 32'hFF, s, 1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(bit [31:0] v, bit [1:0] s, bit l);
      read_result_t e;
      if (expected_reads.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d last=%0b", $time, v, s, l);
        errors++;
        return;
      end
      e = expected_reads.pop_front();
      if (e.value !== v) begin
        $display("%0t: value mismatch, expected %h, actual %h", $time, e.value, v);
        errors++;
      end
      if (e.status !== s) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, s);
        errors++;
      end
      if (e.last !== l) begin
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  mode = 0;
  logic [11:0] length = 0;
  logic [7:0]  data_byte = 0;
  logic [9:0]  bit_count = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] value;
  logic [1:0]  status;
  logic        last;

  reader_scoreboard sb = new();
  bit no_gaps;
  bit stall_done;

  bitstream_reader_exp_golomb dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_bitstream_reader_exp_golomb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_request(mode, length, data_byte, bit_count);
    if (!rst && out_valid && out_ready) sb.check_result(value, status, last);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off once traffic is under way.
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!stall_done && sb.accepted > 150) begin
        stall_done = 1;
        out_ready <= 0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end
      out_ready <= (pick_gap() == 0);
    end
  end

  task automatic send(bit [2:0] m, bit [11:0] len, bit [7:0] db, bit [9:0] cnt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    mode <= m;
    length <= len;
    data_byte <= db;
    bit_count <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_bytes(int n, bit zero_heavy);
    bit [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (zero_heavy && $urandom_range(0, 2) != 0) b = b >> $urandom_range(3, 8);
      send(brx_pkg::MODE_LOAD, 12'($urandom), b, 10'($urandom));
    end
  endtask

  task automatic load_list(bit [7:0] bl[$]);
    foreach (bl[i]) send(brx_pkg::MODE_LOAD, 0, bl[i], 0);
  endtask

  initial begin
    int n;
    bit [2:0] m;
    bit [9:0] cnt;
    repeat (8) @(posedge clk);
    rst <= 0;

    // reads before any buffer exists
    send(brx_pkg::MODE_BITS, 0, 0, 8);
    send(brx_pkg::MODE_EXPG, 0, 0, 0);
    send(brx_pkg::MODE_BYTES, 0, 0, 0);
    send(brx_pkg::MODE_BYTES, 0, 0, 600);
    send(brx_pkg::MODE_BYTES, 0, 0, 19);
    send(3'd5, 12'hFFF, 8'hFF, 10'h3FF);
    send(3'd7, 0, 0, 0);

    // oversized start; reads stay within the loaded bytes
    no_gaps = 1;
    send(brx_pkg::MODE_START, 12'hFFF, 0, 0);
    load_list('{8'hA5, 8'h3C, 8'h96, 8'h5A, 8'hC3, 8'h69, 8'h0F, 8'hF0,
                8'h81, 8'h7E, 8'h24, 8'hDB, 8'h42, 8'hBD, 8'h18, 8'hE7});
    no_gaps = 0;
    send(brx_pkg::MODE_BITS, 0, 0, 0);
    send(brx_pkg::MODE_BITS, 0, 0, 25);
    send(brx_pkg::MODE_BITS, 0, 0, 24);
    send(brx_pkg::MODE_BITS, 0, 0, 1);
    send(brx_pkg::MODE_EXPG, 0, 0, 0);
    send(brx_pkg::MODE_BYTES, 0, 0, 13);

    // end of buffer and sticky end
    send(brx_pkg::MODE_START, 2, 0, 0);
    load_list('{8'hA5, 8'h3C});
    send(brx_pkg::MODE_BITS, 0, 0, 24);
    send(brx_pkg::MODE_BITS, 0, 0, 1);
    // longest byte run, running off a short buffer
    send(brx_pkg::MODE_START, 4, 0, 0);
    load_list('{8'h12, 8'h34, 8'h56, 8'h78});
    send(brx_pkg::MODE_BYTES, 0, 0, 512);
    // prefix runs off the end
    send(brx_pkg::MODE_START, 1, 0, 0);
    load_list('{8'h00});
    send(brx_pkg::MODE_EXPG, 0, 0, 0);
    // suffix too long, then zero counter saturation
    send(brx_pkg::MODE_START, 8, 0, 0);
    load_list('{8'h00, 8'h00, 8'h00, 8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send(brx_pkg::MODE_EXPG, 0, 0, 0);
    send(brx_pkg::MODE_START, 10, 0, 0);
    load_list('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78});
    send(brx_pkg::MODE_EXPG, 0, 0, 0);

    // random: well-formed buffers with random reads, some unused-mode noise
    while (sb.accepted < 330) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 19) == 0) begin
        send(3'($urandom_range(5, 7)), 12'($urandom), 8'($urandom), 10'($urandom));
        continue;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 24);
      send(brx_pkg::MODE_START, 12'(n), 0, 0);
      load_bytes((n > 48) ? 48 : n, $urandom_range(0, 2) == 0);
      repeat ($urandom_range(1, 6)) begin
        m = 3'(brx_pkg::MODE_BITS + $urandom_range(0, 2));
        // a long buffer is only partly loaded: keep its reads short
        if (n > 48) m = brx_pkg::MODE_BITS;
        if (m == brx_pkg::MODE_BITS)
          cnt = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 24));
        else if (m == brx_pkg::MODE_BYTES)
          cnt = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
        else
          cnt = 10'($urandom);
        send(m, 12'($urandom), 8'($urandom), cnt);
      end
    end
    in_valid <= 0;

    n = 0;
    while (sb.expected_reads.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.expected_reads.size() == 0)
      $display("tb_bitstream_reader_exp_golomb OK");
    else
      $display("tb_bitstream_reader_exp_golomb NOT OK");
    $finish;
  end
endmodule
